// ----- rtl/core/udpb_pkg.sv -----
// ----------------------------------------------------------------------------
// UDP port binding table package
// Operation and status codes, header size constants and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package udpb_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int PORT_W   = 16;
    localparam int TAG_W    = 8;
    localparam int PROTO_W  = 8;
    localparam int LEN_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_BIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNBIND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADHDR   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTUDP   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd6;

    localparam logic [PROTO_W-1:0] PROTO_UDP     = 8'd17;
    localparam logic [LEN_W:0]     ETH_IP_BYTES  = 17'd34;
    localparam logic [LEN_W-1:0]   UDP_BYTES     = 16'd8;
    localparam logic [LEN_W-1:0]   MIN_FRAME     = 16'd42;

    typedef struct packed {
        logic load_in;
        logic load_match;
        logic load_pos;
        logic exec;
    } udpb_cmd_t;

endpackage

// ----- rtl/core/udpb_ctrl.sv -----
// ----------------------------------------------------------------------------
// UDP port binding table controller
// Sequences one item through capture, compare, resolve and execute, and owns
// the handshake of both channels.
// ----------------------------------------------------------------------------
module udpb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output udpb_pkg::udpb_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_FIND  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MATCH;
                end
            end
            S_MATCH: begin
                cmd.load_match = 1'b1;
                state_next     = S_FIND;
            end
            S_FIND: begin
                cmd.load_pos = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/core/udpb_datapath.sv -----
// ----------------------------------------------------------------------------
// UDP port binding table datapath
// Holds the row of table cells, the entry count, the captured item, the
// match vector and the result register.
// ----------------------------------------------------------------------------
module udpb_datapath #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  udpb_pkg::udpb_cmd_t                cmd,
    input  logic [udpb_pkg::MODE_W-1:0]        in_mode,
    input  logic [udpb_pkg::PORT_W-1:0]        in_port,
    input  logic [udpb_pkg::TAG_W-1:0]         in_tag,
    input  logic                               in_header_ok,
    input  logic [udpb_pkg::PROTO_W-1:0]       in_protocol,
    input  logic [udpb_pkg::LEN_W-1:0]         in_frame_length,
    input  logic [udpb_pkg::LEN_W-1:0]         in_udp_length,
    output logic [udpb_pkg::STATUS_W-1:0]      out_status,
    output logic [udpb_pkg::SLOT_W-1:0]        out_slot,
    output logic [udpb_pkg::TAG_W-1:0]         out_tag,
    output logic [udpb_pkg::LEN_W-1:0]         out_payload_length,
    output logic                               out_has_payload,
    output logic [udpb_pkg::COUNT_W-1:0]       out_entry_count
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    logic [udpb_pkg::PORT_W-1:0]  port_reg [TABLE_ENTRIES];
    logic [udpb_pkg::TAG_W-1:0]   tag_reg  [TABLE_ENTRIES];
    logic [CW-1:0]                count_reg, count_next;

    logic [udpb_pkg::MODE_W-1:0]  mode_reg;
    logic [udpb_pkg::PORT_W-1:0]  key_reg;
    logic [udpb_pkg::TAG_W-1:0]   new_tag_reg;
    logic                         hdr_ok_reg;
    logic [udpb_pkg::PROTO_W-1:0] proto_reg;
    logic [udpb_pkg::LEN_W-1:0]   flen_reg;
    logic [udpb_pkg::LEN_W-1:0]   ulen_reg;

    logic [TABLE_ENTRIES-1:0]     match_reg, match_next;
    logic [IW-1:0]                pos_reg, pos_next;
    logic                         found_reg, found_next;
    logic [udpb_pkg::TAG_W-1:0]   hit_tag_reg;

    logic [udpb_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [udpb_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [udpb_pkg::TAG_W-1:0]    mtag_reg, mtag_next;
    logic [udpb_pkg::LEN_W-1:0]    plen_reg, plen_next;
    logic                          hasp_reg, hasp_next;

    logic do_append;
    logic do_remove;
    logic too_short;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg    <= in_mode;
            key_reg     <= in_port;
            new_tag_reg <= in_tag;
            hdr_ok_reg  <= in_header_ok;
            proto_reg   <= in_protocol;
            flen_reg    <= in_frame_length;
            ulen_reg    <= in_udp_length;
        end
    end

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_next[i] = (CW'(i) < count_reg) && (port_reg[i] == key_reg);
        end
    end

    always_comb begin
        pos_next   = '0;
        found_next = 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                pos_next   = IW'(i);
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_match) begin
            match_reg <= match_next;
        end
        if (cmd.load_pos) begin
            pos_reg     <= pos_next;
            found_reg   <= found_next;
            hit_tag_reg <= tag_reg[pos_next];
        end
    end

    assign too_short = (flen_reg < udpb_pkg::MIN_FRAME) ||
                       ({1'b0, flen_reg} < (udpb_pkg::ETH_IP_BYTES + {1'b0, ulen_reg}));

    always_comb begin
        status_next = udpb_pkg::ST_OK;
        slot_next   = '0;
        mtag_next   = '0;
        plen_next   = '0;
        hasp_next   = 1'b0;
        count_next  = count_reg;
        do_append   = 1'b0;
        do_remove   = 1'b0;
        unique case (mode_reg)
            udpb_pkg::MODE_BIND: begin
                if (count_reg >= FULL_COUNT) begin
                    status_next = udpb_pkg::ST_FULL;
                end else if (found_reg) begin
                    status_next = udpb_pkg::ST_DUP;
                    slot_next   = udpb_pkg::SLOT_W'(pos_reg);
                end else begin
                    do_append  = 1'b1;
                    slot_next  = udpb_pkg::SLOT_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            udpb_pkg::MODE_UNBIND: begin
                if (!found_reg) begin
                    status_next = udpb_pkg::ST_NOTFOUND;
                end else begin
                    do_remove  = 1'b1;
                    slot_next  = udpb_pkg::SLOT_W'(pos_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            udpb_pkg::MODE_LOOKUP: begin
                if (!hdr_ok_reg) begin
                    status_next = udpb_pkg::ST_BADHDR;
                end else if (proto_reg != udpb_pkg::PROTO_UDP) begin
                    status_next = udpb_pkg::ST_NOTUDP;
                end else if (too_short) begin
                    status_next = udpb_pkg::ST_SHORT;
                end else if (!found_reg) begin
                    status_next = udpb_pkg::ST_NOTFOUND;
                end else begin
                    slot_next = udpb_pkg::SLOT_W'(pos_reg);
                    mtag_next = hit_tag_reg;
                    if (ulen_reg > udpb_pkg::UDP_BYTES) begin
                        plen_next = ulen_reg - udpb_pkg::UDP_BYTES;
                        hasp_next = 1'b1;
                    end
                end
            end
            default: begin
                status_next = udpb_pkg::ST_OK;
            end
        endcase
    end

    // Each cell loads the new entry on an append at its position; every cell but
    // the last takes its upper neighbor when an entry at or below it is removed.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        if (g < TABLE_ENTRIES - 1) begin : g_shift
            always_ff @(posedge aclk) begin
                if (cmd.exec) begin
                    if (do_append && (count_reg == CW'(g))) begin
                        port_reg[g] <= key_reg;
                        tag_reg[g]  <= new_tag_reg;
                    end else if (do_remove && (IW'(g) >= pos_reg)) begin
                        port_reg[g] <= port_reg[g+1];
                        tag_reg[g]  <= tag_reg[g+1];
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge aclk) begin
                if (cmd.exec && do_append && (count_reg == CW'(g))) begin
                    port_reg[g] <= key_reg;
                    tag_reg[g]  <= new_tag_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            mtag_reg   <= mtag_next;
            plen_reg   <= plen_next;
            hasp_reg   <= hasp_next;
        end
    end

    assign out_status         = status_reg;
    assign out_slot           = slot_reg;
    assign out_tag            = mtag_reg;
    assign out_payload_length = plen_reg;
    assign out_has_payload    = hasp_reg;
    assign out_entry_count    = udpb_pkg::COUNT_W'(count_reg);

endmodule

// ----- rtl/core/udp_port_binding_table_top.sv -----
// ----------------------------------------------------------------------------
// UDP port binding table
// Keeps an ordered table of bound UDP ports with handler tags, and serves
// bind, unbind and receive lookup requests.
// ----------------------------------------------------------------------------
// Usage:
// Each input item carries a mode (bind, unbind or receive lookup) and the
// fields that the mode needs. Each accepted item yields exactly one result
// item on the m_ channel with a status code, the slot touched or matched,
// the matched tag and payload length on a good lookup, and the entry count
// after the operation.
// A result is valid once its item has been captured at the accepting edge
// and has gone, each step registered in turn, through a parallel compare
// of the port against every cell, a priority encode of the match vector,
// and the table update with the result load. The block works on one item
// at a time, so it takes a new item only once the last has reached its
// update. The result register holds one item; while it waits to be taken
// the next item is captured and worked up to its update.
// Reset empties the table at once; stored cells keep stale contents that
// are never read. A stalled receiver holds the result and its payload
// steady and stops the block before the next table update.
// ----------------------------------------------------------------------------
module udp_port_binding_table_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [udpb_pkg::MODE_W-1:0]         s_mode,
    input  logic [udpb_pkg::PORT_W-1:0]         s_port,
    input  logic [udpb_pkg::TAG_W-1:0]          s_handler_tag,
    input  logic                                s_header_ok,
    input  logic [udpb_pkg::PROTO_W-1:0]        s_ip_protocol,
    input  logic [udpb_pkg::LEN_W-1:0]          s_frame_length,
    input  logic [udpb_pkg::LEN_W-1:0]          s_udp_length,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [udpb_pkg::STATUS_W-1:0]       m_status,
    output logic [udpb_pkg::SLOT_W-1:0]         m_slot,
    output logic [udpb_pkg::TAG_W-1:0]          m_matched_tag,
    output logic [udpb_pkg::LEN_W-1:0]          m_payload_length,
    output logic                                m_has_payload,
    output logic [udpb_pkg::COUNT_W-1:0]        m_entry_count
);

    udpb_pkg::udpb_cmd_t cmd;

    udpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    udpb_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .in_mode            (s_mode),
        .in_port            (s_port),
        .in_tag             (s_handler_tag),
        .in_header_ok       (s_header_ok),
        .in_protocol        (s_ip_protocol),
        .in_frame_length    (s_frame_length),
        .in_udp_length      (s_udp_length),
        .out_status         (m_status),
        .out_slot           (m_slot),
        .out_tag            (m_matched_tag),
        .out_payload_length (m_payload_length),
        .out_has_payload    (m_has_payload),
        .out_entry_count    (m_entry_count)
    );

endmodule
